FILE: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine: phase codes,
// command codes, register indexes and the config and result bundles.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // command codes carried in the request mode field
   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNIT_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETUP_UNITS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_TIMEOUT = 2'd2;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // register reset values
   localparam logic [15:0] UNIT_TICKS_RESET  = 16'd8;
   localparam logic [7:0]  SETUP_UNITS_RESET = 8'd2;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   // phase lengths in timing units
   localparam logic [7:0] EDGE_UNITS = 8'd4;
   localparam logic [7:0] HALF_UNITS = 8'd2;
   localparam logic [7:0] ACK_UNITS  = 8'd1;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // bus phases
   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_ST_C,
      PH_SP_A,
      PH_SP_B,
      PH_SP_C,
      PH_WR_SETUP,
      PH_WR_DATA,
      PH_WR_HIGH,
      PH_WR_LOW,
      PH_AK_REL,
      PH_AK_HIGH,
      PH_AK_POLL,
      PH_AK_END,
      PH_RD_LOW,
      PH_RD_HIGH,
      PH_RA_DATA,
      PH_RA_HIGH
   } phase_type;

   typedef struct packed {
      logic [15:0] unit_ticks;
      logic [7:0]  setup_units;
      logic [7:0]  ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
      logic       rejected;
   } result_type;

endpackage

FILE: rtl/core/i2cm_csr.sv
// ----------------------------------------------------------------------------
// i2cm_csr
// Configuration registers of the I2C master bit engine, written through a
// plain write port; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module i2cm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output i2cm_pkg::cfg_type                     cfg
);

   i2cm_pkg::cfg_type cfg_ff;
   i2cm_pkg::cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            i2cm_pkg::CSR_UNIT_TICKS:  cfg_in.unit_ticks  = csr_wdata;
            i2cm_pkg::CSR_SETUP_UNITS: cfg_in.setup_units = csr_wdata[7:0];
            i2cm_pkg::CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_wdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_ticks  <= i2cm_pkg::UNIT_TICKS_RESET;
         cfg_ff.setup_units <= i2cm_pkg::SETUP_UNITS_RESET;
         cfg_ff.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus phase sequencer: advances the phase, timing counters and shift
// register by one tick per step and forms that tick's result.
// ----------------------------------------------------------------------------
module i2cm_engine #(
   parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [2:0]             mode,
   input  logic [7:0]             tx_byte,
   input  logic                   send_ack,
   input  logic                   sda_in,
   input  i2cm_pkg::cfg_type      cfg,
   output i2cm_pkg::result_type   result
);

   localparam logic [31:0] TICK_MAX = (TICK_COUNTER_WIDTH >= 32) ? 32'hFFFF_FFFF
                                    : ((32'd1 << TICK_COUNTER_WIDTH) - 32'd1);

   // state registers
   i2cm_pkg::phase_type            phase_ff, phase_in;
   logic [3:0]                     bit_count_ff, bit_count_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [TICK_COUNTER_WIDTH-1:0]  tick_ff, tick_in;
   logic [7:0]                     unit_ff, unit_in;
   logic [7:0]                     poll_ff, poll_in;
   logic                           scl_ff, scl_in;
   logic                           sda_ff, sda_lvl_in;
   logic                           drive_ff, drive_in;
   logic                           ack_choice_ff, ack_choice_in;
   logic [7:0]                     rx_ff, rx_in;
   logic                           err_ff, err_in;
   logic                           sample_ff, sample_in;

   // intermediate values between phase decision and entry actions
   logic                           cmd;
   logic                           enter_go;
   logic                           done;
   logic                           rej;
   logic [3:0]                     bit_count_inc;
   logic [7:0]                     shift_mid;
   logic                           sample_mid;
   logic                           scl_mid;
   logic [7:0]                     poll_mid;
   logic [TICK_COUNTER_WIDTH-1:0]  tick_mid;
   logic [7:0]                     unit_mid;
   logic [15:0]                    reload_raw;
   logic [TICK_COUNTER_WIDTH-1:0]  tick_reload;
   logic                           wait_load;
   logic [7:0]                     wait_units;

   assign cmd = (mode == i2cm_pkg::MODE_START) || (mode == i2cm_pkg::MODE_STOP) ||
                (mode == i2cm_pkg::MODE_WRITE) || (mode == i2cm_pkg::MODE_READ);
   assign bit_count_inc = bit_count_ff + 4'd1;

   // ticks per unit minus one, zero treated as one, saturated to counter width
   assign reload_raw  = (cfg.unit_ticks == 16'd0) ? 16'd0 : (cfg.unit_ticks - 16'd1);
   assign tick_reload = ({16'd0, reload_raw} > TICK_MAX) ? '1
                                                         : TICK_COUNTER_WIDTH'(reload_raw);

   // next phase, countdown and command intake
   always_comb begin
      phase_in      = phase_ff;
      enter_go      = 1'b0;
      done          = 1'b0;
      rej           = 1'b0;
      bit_count_in  = bit_count_ff;
      poll_mid      = poll_ff;
      tick_mid      = tick_ff;
      unit_mid      = unit_ff;
      err_in        = err_ff;
      rx_in         = rx_ff;
      sample_mid    = sample_ff;
      shift_mid     = shift_ff;
      scl_mid       = scl_ff;
      ack_choice_in = ack_choice_ff;
      if (phase_ff != i2cm_pkg::PH_IDLE) begin
         rej = cmd;
         // read data bit taken the tick after scl rises
         if (sample_ff) begin
            shift_mid  = {shift_ff[6:0], sda_in};
            sample_mid = 1'b0;
         end
         if (phase_ff == i2cm_pkg::PH_AK_POLL) begin
            priority if (!sda_in) begin
               phase_in = i2cm_pkg::PH_AK_END;
               enter_go = 1'b1;
            end else if (poll_ff >= cfg.ack_timeout) begin
               err_in   = 1'b1;
               phase_in = i2cm_pkg::PH_SP_A;
               enter_go = 1'b1;
            end else begin
               poll_mid = poll_ff + 8'd1;
            end
         end else if (tick_ff != '0) begin
            tick_mid = tick_ff - TICK_COUNTER_WIDTH'(1);
         end else if (unit_ff != 8'd0) begin
            unit_mid = unit_ff - 8'd1;
            tick_mid = tick_reload;
         end else begin
            // wait expired: move to the following phase
            enter_go = 1'b1;
            unique case (phase_ff)
               i2cm_pkg::PH_ST_A:     phase_in = i2cm_pkg::PH_ST_B;
               i2cm_pkg::PH_ST_B:     phase_in = i2cm_pkg::PH_ST_C;
               i2cm_pkg::PH_SP_A:     phase_in = i2cm_pkg::PH_SP_B;
               i2cm_pkg::PH_SP_B:     phase_in = i2cm_pkg::PH_SP_C;
               i2cm_pkg::PH_WR_SETUP: phase_in = i2cm_pkg::PH_WR_DATA;
               i2cm_pkg::PH_WR_DATA:  phase_in = i2cm_pkg::PH_WR_HIGH;
               i2cm_pkg::PH_WR_HIGH:  phase_in = i2cm_pkg::PH_WR_LOW;
               i2cm_pkg::PH_WR_LOW: begin
                  bit_count_in = bit_count_inc;
                  phase_in = (bit_count_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                             i2cm_pkg::PH_AK_REL : i2cm_pkg::PH_WR_DATA;
               end
               i2cm_pkg::PH_AK_REL:   phase_in = i2cm_pkg::PH_AK_HIGH;
               i2cm_pkg::PH_AK_HIGH:  phase_in = i2cm_pkg::PH_AK_POLL;
               i2cm_pkg::PH_RD_LOW:   phase_in = i2cm_pkg::PH_RD_HIGH;
               i2cm_pkg::PH_RD_HIGH: begin
                  bit_count_in = bit_count_inc;
                  phase_in = (bit_count_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                             i2cm_pkg::PH_RA_DATA : i2cm_pkg::PH_RD_LOW;
               end
               i2cm_pkg::PH_RA_DATA:  phase_in = i2cm_pkg::PH_RA_HIGH;
               i2cm_pkg::PH_RA_HIGH: begin
                  enter_go = 1'b0;
                  scl_mid  = 1'b0;
                  rx_in    = shift_mid;
                  phase_in = i2cm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
               default: begin
                  enter_go = 1'b0;
                  phase_in = i2cm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            endcase
         end
      end else if (cmd) begin
         // new command from idle
         err_in       = 1'b0;
         bit_count_in = 4'd0;
         enter_go     = 1'b1;
         unique case (mode)
            i2cm_pkg::MODE_START: phase_in = i2cm_pkg::PH_ST_A;
            i2cm_pkg::MODE_STOP:  phase_in = i2cm_pkg::PH_SP_A;
            i2cm_pkg::MODE_WRITE: begin
               shift_mid = tx_byte;
               phase_in  = i2cm_pkg::PH_WR_SETUP;
            end
            default: begin
               shift_mid     = 8'd0;
               ack_choice_in = send_ack;
               phase_in      = i2cm_pkg::PH_RD_LOW;
            end
         endcase
      end
   end

   // levels and wait loads applied on entry to a phase
   always_comb begin
      scl_in     = scl_mid;
      sda_lvl_in = sda_ff;
      drive_in   = drive_ff;
      shift_in   = shift_mid;
      sample_in  = sample_mid;
      poll_in    = poll_mid;
      wait_load  = 1'b0;
      wait_units = 8'd0;
      if (enter_go) begin
         unique case (phase_in)
            i2cm_pkg::PH_ST_A: begin
               drive_in = 1'b1; sda_lvl_in = 1'b1; scl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_ST_B: begin
               sda_lvl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_ST_C: begin
               scl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_SP_A: begin
               drive_in = 1'b1; scl_in = 1'b0; sda_lvl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_SP_B: begin
               scl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_SP_C: begin
               sda_lvl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::EDGE_UNITS;
            end
            i2cm_pkg::PH_WR_SETUP: begin
               drive_in = 1'b1; scl_in = 1'b0;
               wait_load = 1'b1; wait_units = cfg.setup_units;
            end
            i2cm_pkg::PH_WR_DATA: begin
               sda_lvl_in = shift_mid[7];
               shift_in   = {shift_mid[6:0], 1'b0};
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            i2cm_pkg::PH_WR_HIGH: begin
               scl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            i2cm_pkg::PH_WR_LOW: begin
               scl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            i2cm_pkg::PH_AK_REL: begin
               drive_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::ACK_UNITS;
            end
            i2cm_pkg::PH_AK_HIGH: begin
               scl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::ACK_UNITS;
            end
            i2cm_pkg::PH_AK_POLL: poll_in = 8'd0;
            i2cm_pkg::PH_AK_END: begin
               scl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::ACK_UNITS;
            end
            i2cm_pkg::PH_RD_LOW: begin
               drive_in = 1'b0; scl_in = 1'b0;
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            i2cm_pkg::PH_RD_HIGH: begin
               scl_in = 1'b1; sample_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::ACK_UNITS;
            end
            i2cm_pkg::PH_RA_DATA: begin
               scl_in = 1'b0; drive_in = 1'b1; sda_lvl_in = ~ack_choice_in;
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            i2cm_pkg::PH_RA_HIGH: begin
               scl_in = 1'b1;
               wait_load = 1'b1; wait_units = i2cm_pkg::HALF_UNITS;
            end
            default: wait_load = 1'b0;
         endcase
      end
   end

   // wait counters: load on entry, else countdown value
   always_comb begin
      if (wait_load) begin
         unit_in = (wait_units == 8'd0) ? 8'd0 : (wait_units - 8'd1);
         tick_in = (wait_units == 8'd0) ? '0 : tick_reload;
      end else begin
         unit_in = unit_mid;
         tick_in = tick_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         tick_ff       <= '0;
         unit_ff       <= 8'd0;
         poll_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b0;
         ack_choice_ff <= 1'b0;
         rx_ff         <= 8'd0;
         err_ff        <= 1'b0;
         sample_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         unit_ff       <= unit_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_lvl_in;
         drive_ff      <= drive_in;
         ack_choice_ff <= ack_choice_in;
         rx_ff         <= rx_in;
         err_ff        <= err_in;
         sample_ff     <= sample_in;
      end
   end

   // result of this tick
   always_comb begin
      result.scl       = scl_in;
      result.sda_out   = sda_lvl_in;
      result.sda_oe    = drive_in;
      result.busy_res  = (phase_in != i2cm_pkg::PH_IDLE);
      result.done_res  = done;
      result.rx_byte   = rx_in;
      result.ack_error = err_in;
      result.rejected  = rej;
   end

   // a completed command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && done) |=> (phase_ff == i2cm_pkg::PH_IDLE))
      else $error("engine not idle after command completion");

   // a request is only rejected while a command runs
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      (step_en && rej) |-> (phase_ff != i2cm_pkg::PH_IDLE))
      else $error("request rejected while idle");

   // a read sample is only pending during the high half of a read bit
   a_sample_phase: assert property (@(posedge clock) disable iff (reset)
      sample_ff |-> (phase_ff == i2cm_pkg::PH_RD_HIGH))
      else $error("read sample pending outside read high phase");

   // bit counter never runs past one byte
   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= i2cm_pkg::BITS_PER_BYTE)
      else $error("bit counter past eight");

endmodule

FILE: rtl/core/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// Byte-level I2C master driving SCL and SDA, one request per bus tick.
// ----------------------------------------------------------------------------
// Each request is one tick of the bus timebase: it carries an optional
// command (start, stop, write byte, read byte) and the sampled SDA level,
// and produces exactly one response with the SCL/SDA levels and status for
// that tick. A request is taken every cycle; its response appears in the
// output register on the following cycle. Requests keep flowing while a
// response waits, as long as the output register is drained in the same
// cycle; with the response side stalled the request side stalls too. All
// bus timing (start/stop edges, bit halves, acknowledge, ack timeout) is
// counted in requests, not clock cycles.
module i2c_master_bit_engine_core #(
   parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_mode,
   input  logic [7:0]                            req_tx_byte,
   input  logic                                  req_send_ack,
   input  logic                                  req_sda_in,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_scl,
   output logic                                  rsp_sda_out,
   output logic                                  rsp_sda_oe,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [7:0]                            rsp_rx_byte,
   output logic                                  rsp_ack_error,
   output logic                                  rsp_rejected,
   // configuration write port
   input  logic                                  csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   i2cm_pkg::cfg_type     cfg;
   i2cm_pkg::result_type  result;
   i2cm_pkg::result_type  rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_take;

   // request accepted when the output register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_engine #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (req_take),
      .mode     (req_mode),
      .tx_byte  (req_tx_byte),
      .send_ack (req_send_ack),
      .sda_in   (req_sda_in),
      .cfg      (cfg),
      .result   (result)
   );

   // output register valid
   always_comb begin
      priority if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = rsp_ff.scl;
   assign rsp_sda_out   = rsp_ff.sda_out;
   assign rsp_sda_oe    = rsp_ff.sda_oe;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_rx_byte   = rsp_ff.rx_byte;
   assign rsp_ack_error = rsp_ff.ack_error;
   assign rsp_rejected  = rsp_ff.rejected;

endmodule

FILE: test/i2c_master_bit_engine_core_checker.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_checker
// Watches the request, response and register ports of the I2C bit engine,
// keeps a tick-accurate copy of the bus engine and compares every response
// field with the level, status and data that copy predicts for its request.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [2:0]                            req_mode,
   input  logic [7:0]                            req_tx_byte,
   input  logic                                  req_send_ack,
   input  logic                                  req_sda_in,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_scl,
   input  logic                                  rsp_sda_out,
   input  logic                                  rsp_sda_oe,
   input  logic                                  rsp_busy_res,
   input  logic                                  rsp_done_res,
   input  logic [7:0]                            rsp_rx_byte,
   input  logic                                  rsp_ack_error,
   input  logic                                  rsp_rejected,
   input  logic                                  csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output int                                    fail_count,
   output int                                    results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   logic [15:0] unit_ticks_q;
   logic [7:0]  setup_q;
   logic [7:0]  ack_limit_q;

   // bus engine copy
   i2cm_pkg::phase_type   bus_phase;
   logic [3:0]  bits_done;
   logic [7:0]  data_shift;
   logic [15:0] tick_left;
   logic [7:0]  units_left;
   logic [7:0]  polls;
   logic        scl_q;
   logic        sda_q;
   logic        sda_en_q;
   logic        ack_pick;
   logic [7:0]  rx_last;
   logic        nack_flag;
   logic        sample_due;

   i2cm_pkg::result_type  bus_expect_q[$];

   // a unit of zero ticks counts as one
   function automatic logic [15:0] unit_reload();
      return (unit_ticks_q == 16'd0) ? 16'd0 : unit_ticks_q - 16'd1;
   endfunction

   function automatic void arm_hold(input logic [7:0] units);
      units_left = (units != 8'd0) ? units - 8'd1 : 8'd0;
      tick_left  = (units != 8'd0) ? unit_reload() : 16'd0;
   endfunction

   // one tick of the current hold; high once the hold has run out
   function automatic logic hold_expired();
      if (tick_left != 16'd0) begin
         tick_left = tick_left - 16'd1;
         return 1'b0;
      end
      if (units_left != 8'd0) begin
         units_left = units_left - 8'd1;
         tick_left  = unit_reload();
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // bus levels and hold time set on entry to a phase
   function automatic void enter_phase(input i2cm_pkg::phase_type p);
      bus_phase = p;
      case (p)
         i2cm_pkg::PH_ST_A: begin
            sda_en_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_ST_B: begin
            sda_q = 1'b0; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_ST_C: begin
            scl_q = 1'b0; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_SP_A: begin
            sda_en_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_SP_B: begin
            scl_q = 1'b1; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_SP_C: begin
            sda_q = 1'b1; arm_hold(i2cm_pkg::EDGE_UNITS);
         end
         i2cm_pkg::PH_WR_SETUP: begin
            sda_en_q = 1'b1; scl_q = 1'b0; arm_hold(setup_q);
         end
         i2cm_pkg::PH_WR_DATA: begin
            sda_q = data_shift[7];
            data_shift = {data_shift[6:0], 1'b0};
            arm_hold(i2cm_pkg::HALF_UNITS);
         end
         i2cm_pkg::PH_WR_HIGH: begin
            scl_q = 1'b1; arm_hold(i2cm_pkg::HALF_UNITS);
         end
         i2cm_pkg::PH_WR_LOW: begin
            scl_q = 1'b0; arm_hold(i2cm_pkg::HALF_UNITS);
         end
         i2cm_pkg::PH_AK_REL: begin
            sda_en_q = 1'b0; arm_hold(i2cm_pkg::ACK_UNITS);
         end
         i2cm_pkg::PH_AK_HIGH: begin
            scl_q = 1'b1; arm_hold(i2cm_pkg::ACK_UNITS);
         end
         i2cm_pkg::PH_AK_POLL: begin
            polls = 8'd0;
         end
         i2cm_pkg::PH_AK_END: begin
            scl_q = 1'b0; arm_hold(i2cm_pkg::ACK_UNITS);
         end
         i2cm_pkg::PH_RD_LOW: begin
            sda_en_q = 1'b0; scl_q = 1'b0; arm_hold(i2cm_pkg::HALF_UNITS);
         end
         i2cm_pkg::PH_RD_HIGH: begin
            scl_q = 1'b1; sample_due = 1'b1; arm_hold(i2cm_pkg::ACK_UNITS);
         end
         i2cm_pkg::PH_RA_DATA: begin
            scl_q = 1'b0; sda_en_q = 1'b1; sda_q = !ack_pick;
            arm_hold(i2cm_pkg::HALF_UNITS);
         end
         i2cm_pkg::PH_RA_HIGH: begin
            scl_q = 1'b1; arm_hold(i2cm_pkg::HALF_UNITS);
         end
         default: begin
            bus_phase = i2cm_pkg::PH_IDLE;
         end
      endcase
   endfunction

   // move on when a hold runs out; high when the command completes
   function automatic logic phase_expired();
      case (bus_phase)
         i2cm_pkg::PH_ST_A:     enter_phase(i2cm_pkg::PH_ST_B);
         i2cm_pkg::PH_ST_B:     enter_phase(i2cm_pkg::PH_ST_C);
         i2cm_pkg::PH_SP_A:     enter_phase(i2cm_pkg::PH_SP_B);
         i2cm_pkg::PH_SP_B:     enter_phase(i2cm_pkg::PH_SP_C);
         i2cm_pkg::PH_WR_SETUP: enter_phase(i2cm_pkg::PH_WR_DATA);
         i2cm_pkg::PH_WR_DATA:  enter_phase(i2cm_pkg::PH_WR_HIGH);
         i2cm_pkg::PH_WR_HIGH:  enter_phase(i2cm_pkg::PH_WR_LOW);
         i2cm_pkg::PH_WR_LOW: begin
            bits_done = bits_done + 4'd1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) enter_phase(i2cm_pkg::PH_AK_REL);
            else enter_phase(i2cm_pkg::PH_WR_DATA);
         end
         i2cm_pkg::PH_AK_REL:   enter_phase(i2cm_pkg::PH_AK_HIGH);
         i2cm_pkg::PH_AK_HIGH:  enter_phase(i2cm_pkg::PH_AK_POLL);
         i2cm_pkg::PH_RD_LOW:   enter_phase(i2cm_pkg::PH_RD_HIGH);
         i2cm_pkg::PH_RD_HIGH: begin
            bits_done = bits_done + 4'd1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) enter_phase(i2cm_pkg::PH_RA_DATA);
            else enter_phase(i2cm_pkg::PH_RD_LOW);
         end
         i2cm_pkg::PH_RA_DATA:  enter_phase(i2cm_pkg::PH_RA_HIGH);
         i2cm_pkg::PH_RA_HIGH: begin
            // read acknowledge ends with scl dropping on the completion tick
            scl_q = 1'b0;
            rx_last = data_shift;
            bus_phase = i2cm_pkg::PH_IDLE;
            return 1'b1;
         end
         default: begin
            bus_phase = i2cm_pkg::PH_IDLE;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // expected response for one request
   function automatic i2cm_pkg::result_type bus_tick(input logic [2:0] m,
                                                     input logic [7:0] tx,
                                                     input logic ak, input logic sd);
      logic                  is_cmd;
      logic                  fin;
      logic                  turned_away;
      i2cm_pkg::result_type  r;
      is_cmd      = (m >= i2cm_pkg::MODE_START) && (m <= i2cm_pkg::MODE_READ);
      fin         = 1'b0;
      turned_away = 1'b0;
      if (bus_phase != i2cm_pkg::PH_IDLE) begin
         // any command while busy is dropped, completion tick included
         if (is_cmd) turned_away = 1'b1;
         if (sample_due) begin
            data_shift = {data_shift[6:0], sd};
            sample_due = 1'b0;
         end
         if (bus_phase == i2cm_pkg::PH_AK_POLL) begin
            if (!sd) begin
               enter_phase(i2cm_pkg::PH_AK_END);
            end else if (polls >= ack_limit_q) begin
               nack_flag = 1'b1;
               enter_phase(i2cm_pkg::PH_SP_A);
            end else begin
               polls = polls + 8'd1;
            end
         end else if (hold_expired()) begin
            fin = phase_expired();
         end
      end else if (is_cmd) begin
         nack_flag = 1'b0;
         bits_done = 4'd0;
         case (m)
            i2cm_pkg::MODE_START: enter_phase(i2cm_pkg::PH_ST_A);
            i2cm_pkg::MODE_STOP:  enter_phase(i2cm_pkg::PH_SP_A);
            i2cm_pkg::MODE_WRITE: begin
               data_shift = tx;
               enter_phase(i2cm_pkg::PH_WR_SETUP);
            end
            default: begin
               data_shift = 8'd0;
               ack_pick = ak;
               enter_phase(i2cm_pkg::PH_RD_LOW);
            end
         endcase
      end
      r.scl       = scl_q;
      r.sda_out   = sda_q;
      r.sda_oe    = sda_en_q;
      r.busy_res  = (bus_phase != i2cm_pkg::PH_IDLE);
      r.done_res  = fin;
      r.rx_byte   = rx_last;
      r.ack_error = nack_flag;
      r.rejected  = turned_away;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      i2cm_pkg::result_type want;
      if (reset) begin
         unit_ticks_q = i2cm_pkg::UNIT_TICKS_RESET;
         setup_q      = i2cm_pkg::SETUP_UNITS_RESET;
         ack_limit_q  = i2cm_pkg::ACK_TIMEOUT_RESET;
         bus_phase    = i2cm_pkg::PH_IDLE;
         bits_done    = 4'd0;
         data_shift   = 8'd0;
         tick_left    = 16'd0;
         units_left   = 8'd0;
         polls        = 8'd0;
         scl_q        = 1'b1;
         sda_q        = 1'b1;
         sda_en_q     = 1'b0;
         ack_pick     = 1'b0;
         rx_last      = 8'd0;
         nack_flag    = 1'b0;
         sample_due   = 1'b0;
         bus_expect_q.delete();
      end else begin
         // compare the response against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (bus_expect_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = bus_expect_q.pop_front();
               check_field("scl", 8'(want.scl), 8'(rsp_scl));
               check_field("sda_out", 8'(want.sda_out), 8'(rsp_sda_out));
               check_field("sda_oe", 8'(want.sda_oe), 8'(rsp_sda_oe));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("ack_error", 8'(want.ack_error), 8'(rsp_ack_error));
               check_field("rejected", 8'(want.rejected), 8'(rsp_rejected));
            end
         end
         // predict the response of an accepted request with the settings before this edge
         if (req_valid && !req_stall) begin
            bus_expect_q.push_back(bus_tick(req_mode, req_tx_byte, req_send_ack, req_sda_in));
         end
         // register writes take effect from the next request on
         if (csr_wr_en) begin
            case (csr_index)
               i2cm_pkg::CSR_UNIT_TICKS:  unit_ticks_q = csr_wdata;
               i2cm_pkg::CSR_SETUP_UNITS: setup_q = csr_wdata[7:0];
               i2cm_pkg::CSR_ACK_TIMEOUT: ack_limit_q = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      results_pending <= bus_expect_q.size();
   end

endmodule

FILE: test/i2c_master_bit_engine_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// Drives bus tick requests into the I2C bit engine: directed start, stop,
// write and read commands over extreme timings, then random transfers over
// several register settings, with random idling on both channels. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned WAIT_LIMIT  = 4000;
   localparam int unsigned RUN_TICKS   = 50;
   localparam int unsigned RUN_COUNT   = 5;

   // modes the block treats as no command
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   // register index with no register behind it
   localparam logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   // how the sda line answers during a command
   localparam int SDA_RANDOM    = 0;
   localparam int SDA_PULLED_UP = 1;
   localparam int SDA_LOW_LEAN  = 2;

   // settings of the random part
   localparam logic [15:0] RUN_UNIT_TICKS  [RUN_COUNT] = '{16'd1, 16'd1, 16'd2, 16'd1, 16'd3};
   localparam logic [7:0]  RUN_SETUP_UNITS [RUN_COUNT] = '{8'd0, 8'd1, 8'd3, 8'd2, 8'd1};
   localparam logic [7:0]  RUN_ACK_TIMEOUT [RUN_COUNT] = '{8'd4, 8'd1, 8'd40, 8'd0, 8'd16};

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [2:0]                            req_mode = i2cm_pkg::MODE_NONE;
   logic [7:0]                            req_tx_byte = 8'd0;
   logic                                  req_send_ack = 1'b0;
   logic                                  req_sda_in = 1'b1;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_scl;
   logic                                  rsp_sda_out;
   logic                                  rsp_sda_oe;
   logic                                  rsp_busy_res;
   logic                                  rsp_done_res;
   logic [7:0]                            rsp_rx_byte;
   logic                                  rsp_ack_error;
   logic                                  rsp_rejected;
   logic                                  csr_wr_en = 1'b0;
   logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index = i2cm_pkg::CSR_UNIT_TICKS;
   logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata = '0;
   int                                    fail_count;
   int                                    results_pending;

   logic        no_idle = 1'b0;
   int unsigned ticks_sent = 0;
   int unsigned done_count = 0;
   int unsigned turned_away = 0;
   int unsigned quiet_cycles = 0;

   i2c_master_bit_engine_core DUT (.*);

   i2c_master_bit_engine_core_checker bus_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side stalls at random
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 36);
   end

   // completed and refused commands, plus the stall watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_done_res) done_count <= done_count + 1;
         if (rsp_rejected) turned_away <= turned_away + 1;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("i2c_master_bit_engine_core verification failed");
         $finish;
      end
   end

   // one request, after a random idle gap
   task automatic put_tick(input logic [2:0] m, input logic [7:0] tx, input logic ak,
                           input logic sd);
      while (!no_idle && ($urandom_range(99) < 36)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_tx_byte  <= tx;
      req_send_ack <= ak;
      req_sda_in   <= sd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   function automatic logic sda_pick(input int pol);
      case (pol)
         SDA_PULLED_UP: return 1'b1;
         SDA_LOW_LEAN:  return ($urandom_range(3) == 0);
         default:       return 1'($urandom_range(1));
      endcase
   endfunction

   // mostly no command, sometimes a command that the busy engine must refuse
   function automatic logic [2:0] filler_mode();
      int unsigned pick;
      pick = $urandom_range(15);
      if (pick == 0) return 3'($urandom_range(i2cm_pkg::MODE_START, i2cm_pkg::MODE_READ));
      if (pick == 1) return 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      return i2cm_pkg::MODE_NONE;
   endfunction

   task automatic wait_done(input int unsigned seen, input int pol);
      int unsigned spent;
      spent = 0;
      while (done_count == seen) begin
         if (spent >= WAIT_LIMIT) begin
            $error("command not completed within %0d ticks", WAIT_LIMIT);
            $display("i2c_master_bit_engine_core verification failed");
            $finish;
         end
         put_tick(filler_mode(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  sda_pick(pol));
         spent++;
      end
   endtask

   task automatic run_cmd(input logic [2:0] m, input logic [7:0] tx, input logic ak,
                          input int pol);
      int unsigned seen;
      seen = done_count;
      put_tick(m, tx, ak, sda_pick(pol));
      wait_done(seen, pol);
   endtask

   // let every outstanding response come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   task automatic set_reg(input logic [i2cm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                          input logic [i2cm_pkg::CSR_DATA_WIDTH-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_timing(input logic [15:0] ut, input logic [7:0] su, input logic [7:0] at);
      set_reg(i2cm_pkg::CSR_UNIT_TICKS, ut);
      set_reg(i2cm_pkg::CSR_SETUP_UNITS, {8'd0, su});
      set_reg(i2cm_pkg::CSR_ACK_TIMEOUT, {8'd0, at});
   endtask

   // one bus transfer, mostly well formed, sometimes a stray command
   task automatic random_transfer();
      int unsigned count;
      if ($urandom_range(7) == 0) begin
         run_cmd(3'($urandom_range(i2cm_pkg::MODE_START, i2cm_pkg::MODE_READ)),
                 8'($urandom_range(255)), 1'($urandom_range(1)),
                 $urandom_range(SDA_LOW_LEAN));
      end else begin
         run_cmd(i2cm_pkg::MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 SDA_RANDOM);
         count = $urandom_range(1, 3);
         repeat (count) begin
            if ($urandom_range(1) == 0) begin
               run_cmd(i2cm_pkg::MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       ($urandom_range(3) == 0) ? SDA_PULLED_UP : SDA_LOW_LEAN);
            end else begin
               run_cmd(i2cm_pkg::MODE_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       SDA_RANDOM);
            end
         end
         // sometimes leave the bus for a repeated start
         if ($urandom_range(7) != 0) begin
            run_cmd(i2cm_pkg::MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    SDA_RANDOM);
         end
      end
   endtask

   initial begin
      int unsigned seen;
      int unsigned mark;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset timing: start and stop
      run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);

      // fastest unit, no setup, short ack wait
      apply_timing(16'd1, 8'd0, 8'd1);
      run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM);
      run_cmd(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, SDA_PULLED_UP);
      run_cmd(i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, SDA_LOW_LEAN);
      run_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b1, SDA_RANDOM);
      run_cmd(i2cm_pkg::MODE_READ, 8'hFF, 1'b0, SDA_RANDOM);
      run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);
      for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) begin
         put_tick(m[2:0], 8'hFF, 1'b1, 1'b0);
      end
      run_cmd(i2cm_pkg::MODE_STOP, 8'h00, 1'b1, SDA_RANDOM);
      set_reg(CSR_SPARE, 16'hFFFF);

      // zero unit, longest setup, no ack poll retries
      apply_timing(16'd0, 8'd255, 8'd0);
      run_cmd(i2cm_pkg::MODE_WRITE, 8'h80, 1'b0, SDA_PULLED_UP);
      run_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b1, SDA_PULLED_UP);
      run_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b0, SDA_LOW_LEAN);

      // longest ack wait ending in the automatic stop
      apply_timing(16'd1, 8'd1, 8'd255);
      run_cmd(i2cm_pkg::MODE_WRITE, 8'h3C, 1'b0, SDA_PULLED_UP);
      run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM);

      // slow unit, shortened while the start is underway
      set_reg(i2cm_pkg::CSR_UNIT_TICKS, 16'd40);
      seen = done_count;
      put_tick(i2cm_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
      repeat (20) put_tick(filler_mode(), 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      set_reg(i2cm_pkg::CSR_UNIT_TICKS, 16'd1);
      wait_done(seen, SDA_RANDOM);

      // random transfers over several timings
      for (int s = 0; s < RUN_COUNT; s++) begin
         apply_timing(RUN_UNIT_TICKS[s], RUN_SETUP_UNITS[s], RUN_ACK_TIMEOUT[s]);
         no_idle <= (s == 1);
         mark = ticks_sent;
         while (ticks_sent - mark < RUN_TICKS) random_transfer();
      end
      no_idle <= 1'b0;

      drain();
      repeat (4) @(posedge clock);
      $display("run covered %0d bus ticks over %0d timing settings", ticks_sent, RUN_COUNT + 5);
      $display("%0d commands completed, %0d refused while busy", done_count, turned_away);
      if (fail_count == 0 && results_pending == 0) begin
         $display("i2c_master_bit_engine_core verification clean");
      end else begin
         $display("i2c_master_bit_engine_core verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_csr.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_bit_engine_core.sv
test/i2c_master_bit_engine_core_checker.sv
test/i2c_master_bit_engine_core_tb.sv
